### hdl/dpe_pkg.sv
// Shared types, constants and step functions for the dual-paraboloid texcoord pipeline.
package dpe_pkg;

  localparam int POS_WIDTH     = 32;
  localparam int TEX_FRAC_BITS = 12;

  // Normalize: magnitudes are aligned so the largest lies in [2^29, 2^30)
  localparam int D_W       = POS_WIDTH + 1;
  localparam int NORM_TOP  = 29;
  localparam int A_W       = NORM_TOP + 1;
  localparam int POS_SH_W  = $clog2(D_W);
  localparam int SHF_W     = D_W + NORM_TOP;
  localparam int SQ_W      = 2 * A_W;
  localparam int ROOT_W    = A_W + 1;
  localparam int S_W       = 2 * ROOT_W;
  localparam int SQ_STEPS  = ROOT_W;
  localparam int SQ_REM_W  = ROOT_W + 3;
  localparam int E_FRAC    = 14;
  localparam int NQ_W      = E_FRAC + 1;
  localparam int N_W       = A_W + E_FRAC + 1;

  // Reflect and rotate
  localparam int DOT_W     = 34;
  localparam int P3_W      = DOT_W + 16;
  localparam int RND_A     = 27;
  localparam int RM_W      = P3_W - RND_A;
  localparam int R_W       = RM_W + 1;
  localparam int MR_W      = 16 + R_W;
  localparam int ACC_W     = MR_W + 2;
  localparam int RND_B     = 14;
  localparam int U_W       = ACC_W - RND_B + 1;

  // Texture quotient
  localparam int NUM_W     = U_W + 1;
  localparam int MAG_W     = NUM_W;
  localparam int X_W       = MAG_W + TEX_FRAC_BITS + 1;
  localparam int Y_W       = MAG_W + 1;
  localparam int QW        = 17;
  localparam int QCAP      = 65536;
  localparam int QS_W      = 18;
  localparam int TS_W      = QS_W + 1;
  localparam int ONE_Q14   = 1 << E_FRAC;
  localparam int HALF_TEX  = 1 << (TEX_FRAC_BITS - 1);

  localparam int CFG_W     = (POS_WIDTH > 48) ? POS_WIDTH : 48;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EYE_X = 3'd0,
    CFG_EYE_Y = 3'd1,
    CFG_EYE_Z = 3'd2,
    CFG_ROT_0 = 3'd3,
    CFG_ROT_1 = 3'd4,
    CFG_ROT_2 = 3'd5
  } dpe_cfg_idx_e;

  typedef struct packed {
    logic signed [POS_WIDTH-1:0] vert_x;
    logic signed [POS_WIDTH-1:0] vert_y;
    logic signed [POS_WIDTH-1:0] vert_z;
    logic signed [15:0]          norm_x;
    logic signed [15:0]          norm_y;
    logic signed [15:0]          norm_z;
  } dpe_in_t;

  typedef struct packed {
    logic signed [15:0] front_u;
    logic signed [15:0] front_v;
    logic signed [15:0] back_u;
    logic signed [15:0] back_v;
    logic signed [15:0] refl_z;
  } dpe_out_t;

  // Unit eye vector and normal, normalize -> reflect
  typedef struct packed {
    logic            valid;
    logic [2:0][15:0] e;
    logic [2:0][15:0] n;
  } dpe_nv_t;

  // Rotated reflection vector, reflect -> texmap
  typedef struct packed {
    logic               valid;
    logic [2:0][U_W-1:0] u;
  } dpe_rv_t;

  typedef struct packed {
    logic     valid;
    dpe_out_t data;
  } dpe_tv_t;

  typedef struct packed {
    logic [2:0]       neg;
    logic             zero;
    logic [2:0][15:0] n;
  } dpe_side_t;

  typedef struct packed {
    logic [ROOT_W-1:0]   root;
    logic [SQ_REM_W-1:0] rem;
    logic [S_W-1:0]      rad;
  } dpe_sq_t;

  typedef struct packed {
    logic [ROOT_W-1:0] rem;
    logic [NQ_W-1:0]   low;
    logic [NQ_W-1:0]   q;
  } dpe_nd_t;

  typedef struct packed {
    logic neg;
    logic nz;
    logic nneg;
    logic dz;
  } dpe_tf_t;

  typedef struct packed {
    logic [Y_W-1:0] rem;
    logic [QW-1:0]  low;
    logic [QW-1:0]  q;
    logic [Y_W-1:0] y;
    logic           ovf;
    dpe_tf_t        fl;
  } dpe_tl_t;

  // One root bit per call
  function automatic dpe_sq_t dpe_sqrt_step(dpe_sq_t x);
    dpe_sq_t             y;
    logic [SQ_REM_W-1:0] sh;
    logic [SQ_REM_W-1:0] trial;
    sh     = {x.rem[SQ_REM_W-3:0], x.rad[S_W-1 -: 2]};
    trial  = {1'b0, x.root, 2'b01};
    y.rad  = {x.rad[S_W-3:0], 2'b00};
    if (sh >= trial) begin
      y.rem  = sh - trial;
      y.root = {x.root[ROOT_W-2:0], 1'b1};
    end else begin
      y.rem  = sh;
      y.root = {x.root[ROOT_W-2:0], 1'b0};
    end
    return y;
  endfunction

  // One quotient bit of the eye-vector division
  function automatic dpe_nd_t dpe_ndiv_step(dpe_nd_t x, logic [ROOT_W-1:0] l);
    dpe_nd_t         y;
    logic [ROOT_W:0] sh;
    sh    = {x.rem, x.low[NQ_W-1]};
    y.low = {x.low[NQ_W-2:0], 1'b0};
    if (sh >= {1'b0, l}) begin
      y.rem = ROOT_W'(sh - {1'b0, l});
      y.q   = {x.q[NQ_W-2:0], 1'b1};
    end else begin
      y.rem = sh[ROOT_W-1:0];
      y.q   = {x.q[NQ_W-2:0], 1'b0};
    end
    return y;
  endfunction

  // One quotient bit of the texture division
  function automatic dpe_tl_t dpe_tdiv_step(dpe_tl_t x);
    dpe_tl_t      y;
    logic [Y_W:0] sh;
    y     = x;
    sh    = {x.rem, x.low[QW-1]};
    y.low = {x.low[QW-2:0], 1'b0};
    if (sh >= {1'b0, x.y}) begin
      y.rem = Y_W'(sh - {1'b0, x.y});
      y.q   = {x.q[QW-2:0], 1'b1};
    end else begin
      y.rem = sh[Y_W-1:0];
      y.q   = {x.q[QW-2:0], 1'b0};
    end
    return y;
  endfunction

  function automatic logic signed [15:0] dpe_sat16(logic signed [31:0] v);
    logic signed [15:0] r;
    if (v > 32'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -32'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

### hdl/dual_paraboloid_envmap_texcoords.sv
// Top level of the dual-paraboloid environment-map texcoord generator.
//
// Input channel in_valid_i/in_ready_o carries one vertex position and unit
// normal per transfer; output channel out_valid_o/out_ready_i carries the
// front and back paraboloid coordinates and the rotated reflection z.
// Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i):
// eye position x/y/z at indexes 0..2, rotation rows at 3..5, other indexes
// are dropped. Write it only while no vertex is in flight.
//
// Throughput is one vertex per clock while the receiver is not stalling.
// A vertex passes through normalization (31 square-root steps and
// 15 division steps, one bit each), reflection and rotation,
// the texture quotients (17 division steps) and one output register.
//
// Reset clears every valid bit, sets the eye to the origin and the
// rotation to identity. When the receiver stalls with a result waiting,
// the whole pipeline holds in place and in_ready_o drops; nothing is
// dropped or repeated.
module dual_paraboloid_envmap_texcoords import dpe_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  dpe_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output dpe_out_t             out_data_o
);

  logic [2:0][POS_WIDTH-1:0] eye_q;
  logic [2:0][47:0]          rot_q;
  logic                      pipe_en;
  logic                      out_valid_q;
  dpe_out_t                  out_data_q;
  dpe_nv_t                   nv;
  dpe_rv_t                   rv;
  dpe_tv_t                   tv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eye_q    <= '0;
      rot_q[0] <= 48'(ONE_Q14);
      rot_q[1] <= 48'(ONE_Q14) << 16;
      rot_q[2] <= 48'(ONE_Q14) << 32;
    end else if (cfg_we_i) begin
      unique case (dpe_cfg_idx_e'(cfg_idx_i))
        CFG_EYE_X: eye_q[0] <= cfg_data_i[POS_WIDTH-1:0];
        CFG_EYE_Y: eye_q[1] <= cfg_data_i[POS_WIDTH-1:0];
        CFG_EYE_Z: eye_q[2] <= cfg_data_i[POS_WIDTH-1:0];
        CFG_ROT_0: rot_q[0] <= cfg_data_i[47:0];
        CFG_ROT_1: rot_q[1] <= cfg_data_i[47:0];
        CFG_ROT_2: rot_q[2] <= cfg_data_i[47:0];
        default: ;
      endcase
    end
  end

  // advance everything unless a result waits on a stalled receiver
  assign pipe_en    = !out_valid_q || out_ready_i;
  assign in_ready_o = pipe_en;

  dpe_normalize u_normalize (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (pipe_en),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .eye_i      (eye_q),
    .out_o      (nv)
  );

  dpe_reflect u_reflect (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .in_i   (nv),
    .rot_i  (rot_q),
    .out_o  (rv)
  );

  dpe_texmap u_texmap (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .in_i   (rv),
    .out_o  (tv)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pipe_en) begin
      out_valid_q <= tv.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en && tv.valid) begin
      out_data_q <= tv.data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTH
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable(tv.valid) && $stable(tv.data))
    else $error("pipeline tail moved during a stall");

  a_load_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pipe_en && tv.valid |=> out_valid_o && (out_data_o == $past(tv.data)))
    else $error("finished result not captured in output register");

  a_cfg_rot0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_idx_i == CFG_ROT_0) |=> rot_q[0] == $past(cfg_data_i[47:0]))
    else $error("rotation row write lost");
`endif

endmodule

### hdl/dpe_normalize.sv
// Eye-to-vertex vector, alignment, pipelined square root and division to a unit vector.
module dpe_normalize import dpe_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       in_valid_i,
  input  dpe_in_t                    in_data_i,
  input  logic [2:0][POS_WIDTH-1:0]  eye_i,
  output dpe_nv_t                    out_o
);

  logic [7:1]            vs_q;
  logic [SQ_STEPS:1]     sqv_q;
  logic [NQ_W:0]         dvv_q;
  logic                  outv_q;

  logic [2:0][D_W-1:0]   d1_q, a2_q, a3_q, a4_q;
  logic [2:0][15:0]      n1_q;
  logic [D_W-1:0]        mx3_q;
  logic [POS_SH_W-1:0]   pos4_q;
  dpe_side_t             sd2_q, sd3_q, sd4_q, sd5_q, sd6_q;
  logic [2:0][A_W-1:0]   a5_q, a6_q;
  logic [2:0][SQ_W-1:0]  sqr6_q;

  dpe_sq_t               sq_q  [SQ_STEPS+1];
  logic [2:0][A_W-1:0]   sa_q  [SQ_STEPS+1];
  dpe_side_t             ssd_q [SQ_STEPS+1];

  dpe_nd_t [2:0]         dv_q  [NQ_W+1];
  logic [ROOT_W-1:0]     dl_q  [NQ_W+1];
  dpe_side_t             dsd_q [NQ_W+1];

  logic [2:0][15:0]      e_q, n_q;

  // valid bits advance with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q   <= '0;
      sqv_q  <= '0;
      dvv_q  <= '0;
      outv_q <= 1'b0;
    end else if (en_i) begin
      vs_q   <= {vs_q[6:1], in_valid_i};
      sqv_q  <= {sqv_q[SQ_STEPS-1:1], vs_q[7]};
      dvv_q  <= {dvv_q[NQ_W-1:0], sqv_q[SQ_STEPS]};
      outv_q <= dvv_q[NQ_W];
    end
  end

  logic [2:0][D_W-1:0]  d1_d, a2_d;
  logic [2:0][POS_WIDTH-1:0] vert;
  logic [D_W-1:0]       mx3_d;
  logic [POS_SH_W-1:0]  pos4_d;
  logic [2:0][A_W-1:0]  a5_d;
  logic [S_W-1:0]       s7_d;
  dpe_nd_t [2:0]        dv0_d;
  logic [2:0][15:0]     e_d;

  assign vert = {in_data_i.vert_z, in_data_i.vert_y, in_data_i.vert_x};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d1_d[i] = {eye_i[i][POS_WIDTH-1], eye_i[i]} - {vert[i][POS_WIDTH-1], vert[i]};
      a2_d[i] = d1_q[i][D_W-1] ? D_W'(-d1_q[i]) : d1_q[i];
    end
    mx3_d = a2_q[0];
    if (a2_q[1] > mx3_d) mx3_d = a2_q[1];
    if (a2_q[2] > mx3_d) mx3_d = a2_q[2];
  end

  // leading-one position of the largest magnitude
  always_comb begin
    pos4_d = '0;
    for (int b = 0; b < D_W; b++) begin
      if (mx3_q[b]) pos4_d = POS_SH_W'(b);
    end
  end

  always_comb begin
    logic [SHF_W-1:0] wide;
    logic [SHF_W-1:0] sh;
    for (int i = 0; i < 3; i++) begin
      wide = {{NORM_TOP{1'b0}}, a4_q[i]};
      if (pos4_q > POS_SH_W'(NORM_TOP)) begin
        sh = wide >> (pos4_q - POS_SH_W'(NORM_TOP));
      end else begin
        sh = wide << (POS_SH_W'(NORM_TOP) - pos4_q);
      end
      a5_d[i] = sh[A_W-1:0];
    end
  end

  assign s7_d = S_W'(sqr6_q[0]) + S_W'(sqr6_q[1]) + S_W'(sqr6_q[2]);

  always_comb begin
    logic [N_W-1:0] num;
    for (int i = 0; i < 3; i++) begin
      num = {sa_q[SQ_STEPS][i], {E_FRAC{1'b0}}}
          + N_W'(sq_q[SQ_STEPS].root >> 1);
      dv0_d[i].rem = ROOT_W'(num >> NQ_W);
      dv0_d[i].low = num[NQ_W-1:0];
      dv0_d[i].q   = '0;
    end
  end

  always_comb begin
    logic [15:0] qe;
    for (int i = 0; i < 3; i++) begin
      qe = {1'b0, dv_q[NQ_W][i].q};
      if (dsd_q[NQ_W].zero) begin
        e_d[i] = '0;
      end else if (dsd_q[NQ_W].neg[i]) begin
        e_d[i] = -qe;
      end else begin
        e_d[i] = qe;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d1_q      <= d1_d;
      n1_q      <= {in_data_i.norm_z, in_data_i.norm_y, in_data_i.norm_x};
      a2_q      <= a2_d;
      sd2_q.neg <= {d1_q[2][D_W-1], d1_q[1][D_W-1], d1_q[0][D_W-1]};
      sd2_q.zero <= 1'b0;
      sd2_q.n   <= n1_q;
      a3_q      <= a2_q;
      mx3_q     <= mx3_d;
      sd3_q     <= sd2_q;
      a4_q      <= a3_q;
      pos4_q    <= pos4_d;
      sd4_q     <= '{neg: sd3_q.neg, zero: (mx3_q == '0), n: sd3_q.n};
      a5_q      <= a5_d;
      sd5_q     <= sd4_q;
      for (int i = 0; i < 3; i++) sqr6_q[i] <= a5_q[i] * a5_q[i];
      a6_q      <= a5_q;
      sd6_q     <= sd5_q;
      sq_q[0]   <= '{root: '0, rem: '0, rad: s7_d};
      sa_q[0]   <= a6_q;
      ssd_q[0]  <= sd6_q;
      dv_q[0]   <= dv0_d;
      dl_q[0]   <= sq_q[SQ_STEPS].root;
      dsd_q[0]  <= ssd_q[SQ_STEPS];
      e_q       <= e_d;
      n_q       <= dsd_q[NQ_W].n;
    end
  end

  for (genvar k = 1; k <= SQ_STEPS; k++) begin : g_sqrt
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_q[k]  <= dpe_sqrt_step(sq_q[k-1]);
        sa_q[k]  <= sa_q[k-1];
        ssd_q[k] <= ssd_q[k-1];
      end
    end
  end

  for (genvar k = 1; k <= NQ_W; k++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int i = 0; i < 3; i++) dv_q[k][i] <= dpe_ndiv_step(dv_q[k-1][i], dl_q[k-1]);
        dl_q[k]  <= dl_q[k-1];
        dsd_q[k] <= dsd_q[k-1];
      end
    end
  end

  assign out_o.valid = outv_q;
  assign out_o.e     = e_q;
  assign out_o.n     = n_q;

endmodule

### hdl/dpe_reflect.sv
// Reflection about the normal and rotation by the inverse camera matrix.
module dpe_reflect import dpe_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  dpe_nv_t          in_i,
  input  logic [2:0][47:0] rot_i,
  output dpe_rv_t          out_o
);

  logic [8:1]              rv_q;
  logic signed [31:0]      p1_q  [3];
  logic [2:0][15:0]        e1_q, n1_q, e2_q, n2_q, e3_q, e4_q;
  logic signed [DOT_W-1:0] dot2_q;
  logic signed [P3_W-1:0]  p3_q  [3];
  logic [RM_W-1:0]         m4_q  [3];
  logic [2:0]              ng4_q;
  logic signed [R_W-1:0]   r5_q  [3];
  logic signed [MR_W-1:0]  mr6_q [9];
  logic signed [ACC_W-1:0] acc7_q [3];
  logic [2:0][U_W-1:0]     u8_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= '0;
    end else if (en_i) begin
      rv_q <= {rv_q[7:1], in_i.valid};
    end
  end

  logic [RM_W-1:0]        m4_d  [3];
  logic signed [R_W-1:0]  r5_d  [3];
  logic [2:0][U_W-1:0]    u8_d;

  // round 2*dot*n to Q14, ties away from zero
  always_comb begin
    logic [P3_W-1:0] mg;
    for (int i = 0; i < 3; i++) begin
      mg      = p3_q[i][P3_W-1] ? P3_W'(-p3_q[i]) : P3_W'(p3_q[i]);
      mg      = mg + (P3_W'(1) << (RND_A - 1));
      m4_d[i] = mg[P3_W-1:RND_A];
    end
  end

  always_comb begin
    logic signed [R_W-1:0] rr;
    for (int i = 0; i < 3; i++) begin
      rr = $signed({1'b0, m4_q[i]});
      if (ng4_q[i]) rr = -rr;
      r5_d[i] = rr - R_W'($signed(e4_q[i]));
    end
  end

  always_comb begin
    logic [ACC_W-1:0] mg;
    logic [U_W-1:0]   uu;
    for (int i = 0; i < 3; i++) begin
      mg = acc7_q[i][ACC_W-1] ? ACC_W'(-acc7_q[i]) : ACC_W'(acc7_q[i]);
      mg = mg + (ACC_W'(1) << (RND_B - 1));
      uu = {1'b0, mg[ACC_W-1:RND_B]};
      u8_d[i] = acc7_q[i][ACC_W-1] ? U_W'(-uu) : uu;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) p1_q[i] <= $signed(in_i.n[i]) * $signed(in_i.e[i]);
      e1_q   <= in_i.e;
      n1_q   <= in_i.n;
      dot2_q <= DOT_W'(p1_q[0]) + DOT_W'(p1_q[1]) + DOT_W'(p1_q[2]);
      e2_q   <= e1_q;
      n2_q   <= n1_q;
      for (int i = 0; i < 3; i++) p3_q[i] <= dot2_q * $signed(n2_q[i]);
      e3_q   <= e2_q;
      m4_q   <= m4_d;
      ng4_q  <= {p3_q[2][P3_W-1], p3_q[1][P3_W-1], p3_q[0][P3_W-1]};
      e4_q   <= e3_q;
      r5_q   <= r5_d;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          mr6_q[3*i+j] <= $signed(rot_i[i][16*j +: 16]) * r5_q[j];
        end
      end
      for (int i = 0; i < 3; i++) begin
        acc7_q[i] <= ACC_W'(mr6_q[3*i]) + ACC_W'(mr6_q[3*i+1]) + ACC_W'(mr6_q[3*i+2]);
      end
      u8_q   <= u8_d;
    end
  end

  assign out_o.valid = rv_q[8];
  assign out_o.u     = u8_q;

endmodule

### hdl/dpe_texmap.sv
// Paraboloid texture coordinates: pipelined saturating quotients and final offset.
module dpe_texmap import dpe_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  dpe_rv_t in_i,
  output dpe_tv_t out_o
);

  localparam logic signed [QS_W-1:0] QS_MAX = QS_W'(32767);
  localparam logic signed [QS_W-1:0] QS_MIN = QS_W'(-32768);

  logic [4:1]              tv_q;
  logic [QW:1]             tlv_q;
  logic                    qv_q, ov_q;

  logic signed [NUM_W-1:0] num1_q [4];
  logic signed [NUM_W-1:0] den1_q [4];
  logic [MAG_W-1:0]        nm2_q  [4];
  logic [MAG_W-1:0]        dm2_q  [4];
  dpe_tf_t                 fl2_q  [4];
  dpe_tf_t                 fl3_q  [4];
  logic [X_W-1:0]          x3_q   [4];
  logic [Y_W-1:0]          y3_q   [4];
  dpe_tl_t [3:0]           tl_q   [QW+1];
  logic signed [15:0]      z_q    [QW+5];
  logic signed [QS_W-1:0]  qs_q   [4];
  dpe_out_t                out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tv_q  <= '0;
      tlv_q <= '0;
      qv_q  <= 1'b0;
      ov_q  <= 1'b0;
    end else if (en_i) begin
      tv_q  <= {tv_q[3:1], in_i.valid};
      tlv_q <= {tlv_q[QW-1:1], tv_q[4]};
      qv_q  <= tlv_q[QW];
      ov_q  <= qv_q;
    end
  end

  logic signed [NUM_W-1:0] num1_d [4];
  logic signed [NUM_W-1:0] den1_d [4];
  dpe_tl_t [3:0]           tl0_d;
  logic signed [QS_W-1:0]  qs_d   [4];
  logic signed [15:0]      res_d  [4];

  always_comb begin
    logic signed [NUM_W-1:0] u0, u1, u2, zf, zb;
    u0 = NUM_W'($signed(in_i.u[0]));
    u1 = NUM_W'($signed(in_i.u[1]));
    u2 = NUM_W'($signed(in_i.u[2]));
    zf = -NUM_W'(ONE_Q14) - u2;
    zb = NUM_W'(ONE_Q14) - u2;
    num1_d[0] = u0;  den1_d[0] = zf;
    num1_d[1] = -u1; den1_d[1] = zf;
    num1_d[2] = u0;  den1_d[2] = zb;
    num1_d[3] = u1;  den1_d[3] = zb;
  end

  // overflow check and first remainder
  always_comb begin
    logic [X_W-1:0] hi;
    for (int l = 0; l < 4; l++) begin
      hi            = x3_q[l] >> QW;
      tl0_d[l].ovf  = hi >= X_W'(y3_q[l]);
      tl0_d[l].rem  = tl0_d[l].ovf ? '0 : hi[Y_W-1:0];
      tl0_d[l].low  = x3_q[l][QW-1:0];
      tl0_d[l].q    = '0;
      tl0_d[l].y    = y3_q[l];
      tl0_d[l].fl   = fl3_q[l];
    end
  end

  always_comb begin
    logic [QW-1:0]         qm;
    logic signed [QS_W-1:0] qq;
    for (int l = 0; l < 4; l++) begin
      qm = tl_q[QW][l].q;
      if (tl_q[QW][l].ovf || qm > QW'(QCAP)) qm = QW'(QCAP);
      qq = $signed({1'b0, qm});
      if (tl_q[QW][l].fl.dz) begin
        if (!tl_q[QW][l].fl.nz) begin
          qs_d[l] = '0;
        end else if (tl_q[QW][l].fl.nneg) begin
          qs_d[l] = QS_MIN;
        end else begin
          qs_d[l] = QS_MAX;
        end
      end else begin
        qs_d[l] = tl_q[QW][l].fl.neg ? -qq : qq;
      end
    end
  end

  always_comb begin
    logic signed [TS_W-1:0] sum;
    for (int l = 0; l < 4; l++) begin
      sum      = TS_W'(qs_q[l]) + TS_W'(HALF_TEX);
      res_d[l] = dpe_sat16(32'(sum));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num1_q <= num1_d;
      den1_q <= den1_d;
      z_q[0] <= dpe_sat16(32'($signed(in_i.u[2])));
      for (int l = 0; l < 4; l++) begin
        nm2_q[l]      <= num1_q[l][NUM_W-1] ? MAG_W'(-num1_q[l]) : MAG_W'(num1_q[l]);
        dm2_q[l]      <= den1_q[l][NUM_W-1] ? MAG_W'(-den1_q[l]) : MAG_W'(den1_q[l]);
        fl2_q[l].neg  <= num1_q[l][NUM_W-1] ^ den1_q[l][NUM_W-1];
        fl2_q[l].nz   <= num1_q[l] != '0;
        fl2_q[l].nneg <= num1_q[l][NUM_W-1];
        fl2_q[l].dz   <= den1_q[l] == '0;
        x3_q[l]       <= (X_W'(nm2_q[l]) << TEX_FRAC_BITS) + X_W'(dm2_q[l]);
        y3_q[l]       <= {dm2_q[l], 1'b0};
        fl3_q[l]      <= fl2_q[l];
      end
      z_q[1]  <= z_q[0];
      z_q[2]  <= z_q[1];
      tl_q[0] <= tl0_d;
      z_q[3]  <= z_q[2];
      qs_q    <= qs_d;
      z_q[QW+4] <= z_q[QW+3];
      out_q.front_u <= res_d[0];
      out_q.front_v <= res_d[1];
      out_q.back_u  <= res_d[2];
      out_q.back_v  <= res_d[3];
      out_q.refl_z  <= z_q[QW+4];
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int l = 0; l < 4; l++) tl_q[k][l] <= dpe_tdiv_step(tl_q[k-1][l]);
        z_q[k+3] <= z_q[k+2];
      end
    end
  end

  assign out_o.valid = ov_q;
  assign out_o.data  = out_q;

endmodule

### bench/tb_top.sv
// Self-checking bench for the dual-paraboloid environment-map texcoord generator.
`timescale 1ns / 1ps

module tb_top;
  import dpe_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd6;
  localparam int unsigned          DRAIN_CYCLES   = 120;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [CFG_W-1:0]     cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  dpe_in_t              in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  dpe_out_t             out_data_o;

  dual_paraboloid_envmap_texcoords i_dut (.*);

  always #5 clk_i = ~clk_i;

  // Configuration copy kept in step with the block's registers
  logic signed [POS_WIDTH-1:0] eye_x = '0, eye_y = '0, eye_z = '0;
  logic [47:0]                 rot_row [3] = '{48'd16384, 48'd16384 << 16, 48'd16384 << 32};

  dpe_in_t  vertex_q [$];
  dpe_out_t texcoord_q [$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_rx = 1'b0;
  int unsigned mismatches = 0;

  function automatic longint round_shift(longint v, int sh);
    longint unsigned m;
    m = ((v < 0 ? -v : v) + (64'd1 << (sh - 1))) >> sh;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic signed [15:0] paraboloid_coord(longint num, longint den);
    longint          q;
    longint unsigned nm, dm, qm;
    if (den == 0) begin
      q = num > 0 ? 32767 : (num < 0 ? -32768 : 0);
    end else begin
      nm = (num < 0 ? -num : num) << (TEX_FRAC_BITS - 1);
      dm = den < 0 ? -den : den;
      qm = (2 * nm + dm) / (2 * dm);
      if (qm > 65536) qm = 65536;
      q = ((num < 0) != (den < 0)) ? -longint'(qm) : longint'(qm);
    end
    q = q + HALF_TEX;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic dpe_out_t predict_texcoords(dpe_in_t v);
    dpe_out_t        o;
    longint          d [3], e [3], n [3], r [3], u [3], m [3][3];
    longint          dot, acc, zf, zb;
    longint unsigned a [3], mx, s, len, bitv, rem;
    d[0] = longint'(eye_x) - longint'(v.vert_x);
    d[1] = longint'(eye_y) - longint'(v.vert_y);
    d[2] = longint'(eye_z) - longint'(v.vert_z);
    n[0] = longint'(v.norm_x);
    n[1] = longint'(v.norm_y);
    n[2] = longint'(v.norm_z);
    for (int i = 0; i < 3; i++) begin
      a[i] = d[i] < 0 ? -d[i] : d[i];
      e[i] = 0;
    end
    mx = a[0];
    if (a[1] > mx) mx = a[1];
    if (a[2] > mx) mx = a[2];
    if (mx != 0) begin
      while (mx >= (64'd1 << 30)) begin
        mx = mx >> 1;
        for (int i = 0; i < 3; i++) a[i] = a[i] >> 1;
      end
      while (mx < (64'd1 << 29)) begin
        mx = mx << 1;
        for (int i = 0; i < 3; i++) a[i] = a[i] << 1;
      end
      s = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
      // Integer square root, two bits per pass
      rem  = s;
      len  = 0;
      bitv = 64'd1 << 62;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (rem >= len + bitv) begin
          rem = rem - (len + bitv);
          len = (len >> 1) + bitv;
        end else begin
          len = len >> 1;
        end
        bitv = bitv >> 2;
      end
      for (int i = 0; i < 3; i++) begin
        e[i] = longint'(((a[i] << 14) + len / 2) / len);
        if (d[i] < 0) e[i] = -e[i];
      end
    end
    dot = n[0] * e[0] + n[1] * e[1] + n[2] * e[2];
    for (int i = 0; i < 3; i++) r[i] = round_shift(2 * dot * n[i], 28) - e[i];
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        m[i][j] = longint'($signed(rot_row[i][16*j +: 16]));
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += m[i][j] * r[j];
      u[i] = round_shift(acc, 14);
    end
    zf = -ONE_Q14 - u[2];
    zb = ONE_Q14 - u[2];
    o.front_u = paraboloid_coord(u[0], zf);
    o.front_v = paraboloid_coord(-u[1], zf);
    o.back_u  = paraboloid_coord(u[0], zb);
    o.back_v  = paraboloid_coord(u[1], zb);
    if (u[2] > 32767) o.refl_z = 16'sh7fff;
    else if (u[2] < -32768) o.refl_z = 16'sh8000;
    else o.refl_z = u[2][15:0];
    return o;
  endfunction

  // Driver: hold the payload until the transfer, then maybe idle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) texcoord_q.push_back(predict_texcoords(in_data_i));
      if (!in_valid_i || in_ready_o) begin
        if (vertex_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= vertex_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare every result transfer with the oldest prediction
  always @(posedge clk_i) begin
    dpe_out_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (texcoord_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_data_o);
        end else begin
          want = texcoord_q.pop_front();
          if (out_data_o.front_u !== want.front_u || out_data_o.front_v !== want.front_v ||
              out_data_o.back_u !== want.back_u || out_data_o.back_v !== want.back_v ||
              out_data_o.refl_z !== want.refl_z) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: exp fu=%0d fv=%0d bu=%0d bv=%0d z=%0d",
                       want.front_u, want.front_v, want.back_u, want.back_v, want.refl_z);
              $display("          got fu=%0d fv=%0d bu=%0d bv=%0d z=%0d",
                       out_data_o.front_u, out_data_o.front_v, out_data_o.back_u,
                       out_data_o.back_v, out_data_o.refl_z);
            end
          end
        end
      end
      out_ready_i <= !hold_rx && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [47:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_W'(val);
    unique case (idx)
      CFG_EYE_X: eye_x = val[POS_WIDTH-1:0];
      CFG_EYE_Y: eye_y = val[POS_WIDTH-1:0];
      CFG_EYE_Z: eye_z = val[POS_WIDTH-1:0];
      CFG_ROT_0: rot_row[0] = val;
      CFG_ROT_1: rot_row[1] = val;
      CFG_ROT_2: rot_row[2] = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic dpe_in_t make_vertex(int vx, int vy, int vz, int nx, int ny, int nz);
    dpe_in_t v;
    v.vert_x = vx;
    v.vert_y = vy;
    v.vert_z = vz;
    v.norm_x = nx[15:0];
    v.norm_y = ny[15:0];
    v.norm_z = nz[15:0];
    return v;
  endfunction

  function automatic int rand_coord();
    if ($urandom_range(3) == 0) return int'($urandom);
    return $urandom_range(2097151) - 1048576;
  endfunction

  function automatic int rand_normal();
    unique case ($urandom_range(3))
      0: return int'($urandom) >>> 16;
      1: return $urandom_range(1) ? 16384 : -16384;
      default: return $urandom_range(32768) - 16384;
    endcase
  endfunction

  function automatic logic [47:0] rand_row();
    return {16'($urandom), 32'($urandom)};
  endfunction

  task automatic wait_idle();
    while (vertex_q.size() != 0 || in_valid_i || texcoord_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset config: identity rotation, eye at origin
    vertex_q.push_back(make_vertex(0, 0, 0, 16384, 0, 0));           // eye on vertex
    vertex_q.push_back(make_vertex(0, 0, -65536, 0, 0, 16384));      // back denominator zero
    vertex_q.push_back(make_vertex(0, 0, -65536, 0, 0, 0));          // front zero over zero
    vertex_q.push_back(make_vertex(-1, 0, -65536, 0, 0, 0));         // off-axis, front den rounds to zero
    vertex_q.push_back(make_vertex(65536, 0, 65536, 0, 0, 0));
    vertex_q.push_back(make_vertex(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                   32767, 32767, 32767));
    vertex_q.push_back(make_vertex(32'h80000000, 32'h80000000, 32'h80000000,
                                   -32768, -32768, -32768));
    vertex_q.push_back(make_vertex(32'h80000000, 32'h7fffffff, 0, -32768, 32767, 0));
    vertex_q.push_back(make_vertex(1, 0, 0, 0, 16384, 0));
    vertex_q.push_back(make_vertex(0, -1, 0, 0, -16384, 0));
    vertex_q.push_back(make_vertex(0, 0, 1, 0, 0, -16384));
    vertex_q.push_back(make_vertex(3, -5, 7, 9459, 9459, 9459));
    vertex_q.push_back(make_vertex(-65536, 65536, -65536, 11585, 0, 11585));
    vertex_q.push_back(make_vertex(0, 0, 32'h80000000, 0, 0, 32767));
    vertex_q.push_back(make_vertex(1000, 2000, -300000, -9459, 9459, -9459));

    for (int ph = 0; ph < 8; ph++) begin
      unique case (ph)
        1: begin
          write_reg(CFG_EYE_X, 48'h7fffffff);
          write_reg(CFG_EYE_Y, 48'hffff80000000);
          write_reg(CFG_EYE_Z, 48'h7fffffff);
          for (int i = 0; i < 3; i++)
            write_reg(CFG_IDX_W'(int'(CFG_ROT_0) + i), rand_row());
        end
        2: begin
          write_reg(CFG_EYE_X, rand_row());
          for (int i = 0; i < 3; i++)
            write_reg(CFG_IDX_W'(int'(CFG_ROT_0) + i), 48'h7fff7fff7fff);
        end
        3: begin
          write_reg(CFG_EYE_X, 48'h80000000);
          write_reg(CFG_EYE_Y, 48'h80000000);
          write_reg(CFG_EYE_Z, 48'h80000000);
          for (int i = 0; i < 3; i++)
            write_reg(CFG_IDX_W'(int'(CFG_ROT_0) + i), 48'h800080008000);
        end
        4: begin
          for (int i = 0; i < 3; i++) write_reg(CFG_IDX_W'(int'(CFG_ROT_0) + i), 48'h0);
          write_reg(CFG_IDX_UNUSED, rand_row());
          write_reg(CFG_IDX_UNUSED + 3'd1, rand_row());
        end
        5, 6: begin
          write_reg(CFG_EYE_X, 48'(rand_coord()));
          write_reg(CFG_EYE_Y, 48'(rand_coord()));
          write_reg(CFG_EYE_Z, 48'(rand_coord()));
          for (int i = 0; i < 3; i++)
            write_reg(CFG_IDX_W'(int'(CFG_ROT_0) + i), rand_row());
        end
        7: begin
          write_reg(CFG_EYE_X, 48'h0);
          write_reg(CFG_EYE_Y, 48'h0);
          write_reg(CFG_EYE_Z, 48'h0);
          write_reg(CFG_ROT_0, 48'd16384);
          write_reg(CFG_ROT_1, 48'd16384 << 16);
          write_reg(CFG_ROT_2, 48'hc00000000000);
        end
        default: ;
      endcase
      unique case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      for (int k = 0; k < 160; k++)
        vertex_q.push_back(make_vertex(rand_coord(), rand_coord(), rand_coord(),
                                       rand_normal(), rand_normal(), rand_normal()));
      if (ph == 1) begin
        // Long receiver hold-off so the pipeline fills and backs up
        @(posedge clk_i);
        hold_rx <= 1'b1;
        repeat (300) @(posedge clk_i);
        hold_rx <= 1'b0;
      end
      wait_idle();
    end

    if (mismatches == 0 && texcoord_q.size() == 0) begin
      $display("dual_paraboloid_envmap_texcoords verification clean");
    end else begin
      $display("dual_paraboloid_envmap_texcoords verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("dual_paraboloid_envmap_texcoords verification failed");
    $finish;
  end

endmodule
